// File: hdl/bcw_pkg.sv
// Package for the tetrahedron barycentric weight pipeline.
// Widths and types shared by all modules, and the lane decode function.
package bcw_pkg;

    localparam int COORD_BITS       = 16;
    localparam int WEIGHT_FRAC_BITS = 16;
    localparam int LANE_BITS        = 16;
    localparam int WORD_BITS        = 3 * LANE_BITS;
    localparam int CB     = (COORD_BITS > LANE_BITS) ? LANE_BITS : COORD_BITS;
    localparam int DIFF_W = CB + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int COF_W  = PROD_W + 1;
    localparam int TERM_W = DIFF_W + COF_W;
    localparam int DET_W  = TERM_W + 2;
    localparam int SUM_W  = DET_W + 2;
    localparam int REM_W  = SUM_W + 1;
    localparam int QINT_BITS = 21;
    localparam int Q_W    = QINT_BITS + WEIGHT_FRAC_BITS + 1;
    localparam int WEIGHT_W = 20;
    localparam int DET_STAGES = 5;
    localparam int LATENCY = DET_STAGES + 1 + 2 + Q_W + 1;

    typedef logic [WORD_BITS-1:0]       t_word;
    typedef logic signed [DIFF_W-1:0]   t_diff;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [COF_W-1:0]    t_cof;
    typedef logic signed [TERM_W-1:0]   t_term;
    typedef logic signed [DET_W-1:0]    t_det;
    typedef logic signed [SUM_W-1:0]    t_sum;
    typedef logic signed [WEIGHT_W-1:0] t_weight;

    typedef struct packed {
        logic vld;
        logic degen;
    } t_ctl;

    localparam t_weight W_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
    localparam t_weight W_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

    function automatic t_diff coord(input t_word word, input int lane);
        logic signed [CB-1:0] c;
        c = word[lane*LANE_BITS +: CB];
        return DIFF_W'(c);
    endfunction

endpackage

// File: hdl/tetrahedron_barycentric_weights.sv
// Tetrahedron barycentric weights. An item is taken whenever start is high;
// busy stays low, so one item enters every clock cycle. Each result passes
// through 5 determinant stages, one sum stage, then 41 divider stages set
// by the 38 quotient bits, one bit per stage, and is shown for one cycle with
// o_valid high; the receiver cannot stall it. Depends on bcw_pkg, bcw_det,
// bcw_div.
module tetrahedron_barycentric_weights (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [47:0]            i_corner_a,
    input  logic [47:0]            i_corner_b,
    input  logic [47:0]            i_corner_c,
    input  logic [47:0]            i_corner_d,
    input  logic [47:0]            i_query_point,
    output logic                   o_valid,
    output logic signed [19:0]     o_weight_a,
    output logic signed [19:0]     o_weight_b,
    output logic signed [19:0]     o_weight_c,
    output logic signed [19:0]     o_weight_d,
    output logic                   o_degenerate
);
    import bcw_pkg::*;

    t_word   pts [5];
    logic    det_vld;
    t_det    det [4];
    logic    r_s_vld;
    t_sum    r_num [4];
    t_sum    r_sum;
    t_ctl    ctl [4];
    t_weight wgt [4];

    assign busy   = 1'b0;
    assign pts[0] = i_corner_a;
    assign pts[1] = i_corner_b;
    assign pts[2] = i_corner_c;
    assign pts[3] = i_corner_d;
    assign pts[4] = i_query_point;

    bcw_det u_det (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start),
        .i_pts   (pts),
        .o_vld   (det_vld),
        .o_det   (det)
    );

    // six-fold volume
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
        end else begin
            r_s_vld <= det_vld;
        end
        for (int i = 0; i < 4; i++)
            r_num[i] <= SUM_W'(det[i]);
        r_sum <= SUM_W'(det[0]) + SUM_W'(det[1]) + SUM_W'(det[2]) + SUM_W'(det[3]);
    end

    for (genvar i = 0; i < 4; i++) begin : g_lane
        bcw_div u_div (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_vld    (r_s_vld),
            .i_num    (r_num[i]),
            .i_den    (r_sum),
            .o_ctl    (ctl[i]),
            .o_weight (wgt[i])
        );
    end

    assign o_valid      = ctl[0].vld;
    assign o_degenerate = ctl[0].degen;
    assign o_weight_a   = wgt[0];
    assign o_weight_b   = wgt[1];
    assign o_weight_c   = wgt[2];
    assign o_weight_d   = wgt[3];

    a_lanes_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl[0] == ctl[1] && ctl[0] == ctl[2] && ctl[0] == ctl[3])
        else $error("divider lanes out of step");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> wgt[0] == '0 && wgt[1] == '0 &&
                                    wgt[2] == '0 && wgt[3] == '0)
        else $error("degenerate item with nonzero weights");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LATENCY))
        else $error("result without matching item");
endmodule

// File: hdl/bcw_det.sv
// Five-stage pipeline that forms the four corner determinants.
// Depends on bcw_pkg.
module bcw_det (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    input  bcw_pkg::t_word i_pts [5],
    output logic           o_vld,
    output bcw_pkg::t_det  o_det [4]
);
    import bcw_pkg::*;

    logic  [DET_STAGES-1:0] r_vld;
    t_diff n_u [4][3], n_v [4][3], n_w [4][3];
    t_diff r_u1 [4][3], r_v1 [4][3], r_w1 [4][3];
    t_diff r_u2 [4][3], r_u3 [4][3];
    t_prod r_p2 [4][6];
    t_cof  r_c3 [4][3];
    t_term r_t4 [4][3];
    t_det  r_det [4];

    always_comb begin
        t_diff rw [4][3];
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++)
                for (int k = 0; k < 3; k++)
                    rw[j][k] = (j == i) ? coord(i_pts[4], k) : coord(i_pts[j], k);
            for (int k = 0; k < 3; k++) begin
                n_u[i][k] = rw[1][k] - rw[0][k];
                n_v[i][k] = rw[2][k] - rw[0][k];
                n_w[i][k] = rw[3][k] - rw[0][k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[DET_STAGES-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_u1[i] <= n_u[i];
            r_v1[i] <= n_v[i];
            r_w1[i] <= n_w[i];
            r_p2[i][0] <= PROD_W'(r_v1[i][1]) * PROD_W'(r_w1[i][2]);
            r_p2[i][1] <= PROD_W'(r_v1[i][2]) * PROD_W'(r_w1[i][1]);
            r_p2[i][2] <= PROD_W'(r_v1[i][0]) * PROD_W'(r_w1[i][2]);
            r_p2[i][3] <= PROD_W'(r_v1[i][2]) * PROD_W'(r_w1[i][0]);
            r_p2[i][4] <= PROD_W'(r_v1[i][0]) * PROD_W'(r_w1[i][1]);
            r_p2[i][5] <= PROD_W'(r_v1[i][1]) * PROD_W'(r_w1[i][0]);
            r_u2[i] <= r_u1[i];
            for (int k = 0; k < 3; k++)
                r_c3[i][k] <= COF_W'(r_p2[i][2*k]) - COF_W'(r_p2[i][2*k+1]);
            r_u3[i] <= r_u2[i];
            for (int k = 0; k < 3; k++)
                r_t4[i][k] <= TERM_W'(r_u3[i][k]) * TERM_W'(r_c3[i][k]);
            r_det[i] <= DET_W'(r_t4[i][0]) - DET_W'(r_t4[i][1]) + DET_W'(r_t4[i][2]);
        end
    end

    assign o_vld = r_vld[DET_STAGES-1];
    assign o_det = r_det;
endmodule

// File: hdl/bcw_div.sv
// Pipelined restoring divider for one weight: sign/abs, range check,
// one quotient bit per stage, then round and saturate, or zero on a degenerate item. Depends on bcw_pkg.
module bcw_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  bcw_pkg::t_sum    i_num,
    input  bcw_pkg::t_sum    i_den,
    output bcw_pkg::t_ctl    o_ctl,
    output bcw_pkg::t_weight o_weight
);
    import bcw_pkg::*;

    logic               r_a_vld, r_a_neg, r_a_degen;
    logic [SUM_W-1:0]   r_a_n, r_a_d;
    logic               r_vld [Q_W+1];
    logic               r_neg [Q_W+1];
    logic               r_sat [Q_W+1];
    logic               r_dgn [Q_W+1];
    logic [SUM_W-1:0]   r_d   [Q_W+1];
    logic [REM_W-1:0]   r_rem [Q_W+1];
    logic [Q_W-1:0]     r_nb  [Q_W+1];
    logic [Q_W-1:0]     r_q   [Q_W+1];
    t_ctl               r_ctl;
    t_weight            r_weight;
    logic [Q_W:0]       n_round;
    logic [Q_W-1:0]     n_mag;
    t_weight            n_weight;

    // stage A: sign and magnitudes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= i_vld;
        end
        r_a_neg   <= i_num[SUM_W-1] ^ i_den[SUM_W-1];
        r_a_degen <= (i_den == '0);
        r_a_n     <= i_num[SUM_W-1] ? SUM_W'(-i_num) : SUM_W'(i_num);
        r_a_d     <= i_den[SUM_W-1] ? SUM_W'(-i_den) : SUM_W'(i_den);
    end

    // stage B: integer part range check, seed the remainder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= r_a_vld;
        end
        r_neg[0] <= r_a_neg;
        r_dgn[0] <= r_a_degen;
        r_d[0]   <= r_a_d;
        r_sat[0] <= {QINT_BITS'(0), r_a_n} >= {r_a_d, QINT_BITS'(0)};
        r_rem[0] <= REM_W'(r_a_n >> QINT_BITS);
        r_nb[0]  <= {r_a_n[QINT_BITS-1:0], (WEIGHT_FRAC_BITS+1)'(0)};
        r_q[0]   <= '0;
    end

    for (genvar k = 0; k < Q_W; k++) begin : g_step
        logic [REM_W-1:0] sh;
        logic             ge;
        assign sh = {r_rem[k][REM_W-2:0], r_nb[k][Q_W-1]};
        assign ge = sh >= {1'b0, r_d[k]};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
            r_neg[k+1] <= r_neg[k];
            r_sat[k+1] <= r_sat[k];
            r_dgn[k+1] <= r_dgn[k];
            r_d[k+1]   <= r_d[k];
            r_rem[k+1] <= ge ? sh - {1'b0, r_d[k]} : sh;
            r_nb[k+1]  <= {r_nb[k][Q_W-2:0], 1'b0};
            r_q[k+1]   <= {r_q[k][Q_W-2:0], ge};
        end
    end

    // zero for a degenerate item, else round half away from zero on the magnitude, then clamp
    always_comb begin
        n_round = {1'b0, r_q[Q_W]} + (Q_W+1)'(1);
        n_mag   = n_round[Q_W:1];
        if (r_dgn[Q_W]) begin
            n_weight = '0;
        end else if (!r_neg[Q_W]) begin
            n_weight = (r_sat[Q_W] || n_mag > Q_W'(W_MAX)) ? W_MAX
                                                           : t_weight'(n_mag[WEIGHT_W-1:0]);
        end else if (r_sat[Q_W] || n_mag > Q_W'({1'b0, W_MIN})) begin
            n_weight = W_MIN;
        end else begin
            n_weight = -t_weight'(n_mag[WEIGHT_W-1:0]);
        end
    end

    // drop the flag when no item is present so it never carries unfilled data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= '{vld: r_vld[Q_W], degen: r_vld[Q_W] & r_dgn[Q_W]};
        end
        r_weight <= n_weight;
    end

    assign o_ctl    = r_ctl;
    assign o_weight = r_weight;
endmodule
